>>> rtl/core/programmable_dfa_runner_defines.svh
// assertion macros shared by the dfa runner rtl
`ifndef PROGRAMMABLE_DFA_RUNNER_DEFINES_SVH
`define PROGRAMMABLE_DFA_RUNNER_DEFINES_SVH

`ifndef SYNTHESIS

// checked property, quiet while rst_n is low
`define PDFA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// checked property, also sampled during reset
`define PDFA_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`else

`define PDFA_ASSERT(label, prop)
`define PDFA_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> rtl/core/pdfa_pkg.sv
// package: widths, codes and state type of the dfa runner
`timescale 1ns / 1ps

package pdfa_pkg;

    localparam int STATE_W     = 4;
    localparam int SYMBOL_W    = 8;
    localparam int INDEX_W     = 4;
    localparam int OPCODE_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int MASK_W      = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [OPCODE_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_STEP    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_STATE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPTING_MASK = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } fsm_t;

endpackage

>>> rtl/core/pdfa_ifs.sv
// channel interfaces: input items, results and configuration writes
`timescale 1ns / 1ps

interface pdfa_item_if;
    import pdfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  entry_index;
    logic [STATE_W-1:0]  from_state;
    logic [SYMBOL_W-1:0] symbol;
    logic [STATE_W-1:0]  to_state;

    modport source (output valid, opcode, entry_index, from_state, symbol, to_state,
                    input ready);
    modport sink (input valid, opcode, entry_index, from_state, symbol, to_state,
                  output ready);
endinterface

interface pdfa_result_if;
    import pdfa_pkg::*;

    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] present_state;
    logic               is_accepting;
    logic               matched;

    modport source (output valid, present_state, is_accepting, matched, input ready);
    modport sink (input valid, present_state, is_accepting, matched, output ready);
endinterface

interface pdfa_cfg_if;
    import pdfa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/pdfa_table.sv
// transition table memory: one write port, one registered read port
`timescale 1ns / 1ps

module pdfa_table #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/programmable_dfa_runner.sv
// top level: programmable table-driven dfa runner
`timescale 1ns / 1ps
// Programmable deterministic automaton with a transition table in on-chip memory.
// item channel: opcode 0 writes table slot entry_index with (from_state, symbol,
// to_state), opcode 1 steps the automaton on symbol, opcode 2 restarts it.
// result channel: one transfer per item with present_state, is_accepting, matched.
// cfg channel: index 0 initial_state, 1 accepting_mask, 2 entry_count; always ready;
// the user must write it only while the block is idle; the block does not enforce this.
// Write, restart and unused opcodes pass through the EMIT state into the output
// register. A step reads the table one slot per cycle through the single memory
// read port, stopping at the first match, and reads at most the saturated
// entry_count slots. One item is in work at a time; the next item is taken as
// soon as the previous result sits in the output register.
// Reset clears the state to 0, the flag and the control and cfg registers; the table holds
// garbage until written, no clearing pass is run.
// A stalled result holds in the output register; the block accepts the next item
// and finishes it, then waits until the output register frees up.
module programmable_dfa_runner #(
    parameter int ENTRIES     = 16,
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8
) (
    input  logic   clk,
    input  logic   rst_n,
    pdfa_item_if.sink     item,
    pdfa_result_if.source result,
    pdfa_cfg_if.sink      cfg
);
    import pdfa_pkg::*;

    `include "programmable_dfa_runner_defines.svh"

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = (SYMBOL_BITS < SYMBOL_W) ? SYMBOL_BITS : SYMBOL_W;
    localparam int EW = STATE_W + SW + STATE_W;

    fsm_t state_reg, state_next;

    logic [STATE_W-1:0] init_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [CW-1:0]      scan_idx_reg, scan_idx_next;
    logic [CW-1:0]      limit_reg, limit_next;
    logic [SW-1:0]      sym_reg, sym_next;
    logic [STATE_W-1:0] cur_state_reg, cur_state_next;
    logic               flag_reg, flag_next;
    logic               hit_reg, hit_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic [STATE_W-1:0] out_state_reg;
    logic               out_flag_reg;
    logic               out_hit_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [EW-1:0]      wr_data;
    logic [AW-1:0]      rd_addr;
    logic [EW-1:0]      rd_data;

    logic               write_ok;
    logic [CW-1:0]      limit_sat;
    logic [STATE_W-1:0] rd_from;
    logic [SW-1:0]      rd_sym;
    logic [STATE_W-1:0] rd_to;
    logic               rd_match;

    pdfa_table #(
        .DEPTH  (ENTRIES),
        .WIDTH  (EW),
        .ADDR_W (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign write_ok = (int'(item.entry_index) < ENTRIES)
                   && (int'(item.from_state) < NUM_STATES)
                   && (int'(item.to_state) < NUM_STATES);

    // entry_count saturates at the table depth
    assign limit_sat = (int'(count_reg) > ENTRIES) ? CW'(ENTRIES) : CW'(count_reg);

    assign wr_addr = AW'(item.entry_index);
    assign wr_data = {item.from_state, item.symbol[SW-1:0], item.to_state};

    assign rd_from  = rd_data[EW-1 -: STATE_W];
    assign rd_sym   = rd_data[STATE_W +: SW];
    assign rd_to    = rd_data[STATE_W-1:0];
    assign rd_match = (rd_from == cur_state_reg) && (rd_sym == sym_reg);

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= '0;
            mask_reg  <= '0;
            count_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_INITIAL_STATE:  init_reg  <= cfg.data[STATE_W-1:0];
                REG_ACCEPTING_MASK: mask_reg  <= cfg.data[MASK_W-1:0];
                REG_ENTRY_COUNT:    count_reg <= cfg.data[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state, scan control and table access
    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        limit_next     = limit_reg;
        sym_next       = sym_reg;
        cur_state_next = cur_state_reg;
        flag_next      = flag_reg;
        hit_next       = hit_reg;
        item.ready     = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = scan_idx_reg[AW-1:0];
        out_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                item.ready = 1'b1;
                rd_addr    = '0;
                // ready is high throughout idle, so valid alone marks the transfer
                if (item.valid)
                begin
                    hit_next   = 1'b0;
                    state_next = S_EMIT;
                    case (item.opcode)
                        OP_WRITE:
                        begin
                            wr_en = write_ok;
                        end
                        OP_STEP:
                        begin
                            // slot 0 is read this cycle, the scan goes on from slot 1
                            limit_next    = limit_sat;
                            sym_next      = item.symbol[SW-1:0];
                            scan_idx_next = CW'(1);
                            if (limit_sat != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_RESTART:
                        begin
                            cur_state_next = init_reg;
                            flag_next      = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // rd_data holds slot scan_idx_reg - 1
                if (rd_match)
                begin
                    cur_state_next = rd_to;
                    flag_next      = mask_reg[rd_to];
                    hit_next       = 1'b1;
                    state_next     = S_EMIT;
                end
                else if (scan_idx_reg == limit_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control and automaton state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            limit_reg     <= '0;
            cur_state_reg <= '0;
            flag_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_idx_reg  <= scan_idx_next;
            limit_reg     <= limit_next;
            cur_state_reg <= cur_state_next;
            flag_reg      <= flag_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        if (out_load)
        begin
            out_state_reg <= cur_state_reg;
            out_flag_reg  <= flag_reg;
            out_hit_reg   <= hit_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.present_state = out_state_reg;
    assign result.is_accepting  = out_flag_reg;
    assign result.matched       = out_hit_reg;

    `PDFA_ASSERT(a_scan_in_range, (state_reg == S_SCAN) |-> (scan_idx_reg <= limit_reg))
    `PDFA_ASSERT(a_scan_nonempty, (state_reg == S_SCAN) |-> (limit_reg != '0))
    `PDFA_ASSERT(a_hit_from_scan, $rose(hit_reg) |-> ($past(state_reg) == S_SCAN))
    `PDFA_ASSERT(a_emit_loads_out,
        (state_reg == S_EMIT && (!out_valid_reg || result.ready))
        |=> (out_valid_reg && state_reg == S_IDLE))
    `PDFA_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> (state_reg == S_IDLE && !out_valid_reg))

endmodule

>>> verif/tb_top.sv
// testbench for the programmable dfa runner: random traffic checked against a predictor
`timescale 1ns / 1ps

module tb_top;
    import pdfa_pkg::*;

    localparam int TABLE_SLOTS = 16;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  entry_index;
        logic [STATE_W-1:0]  from_state;
        logic [SYMBOL_W-1:0] symbol;
        logic [STATE_W-1:0]  to_state;
    } dfa_item_t;

    typedef struct packed {
        logic [STATE_W-1:0] present_state;
        logic               is_accepting;
        logic               matched;
    } dfa_outcome_t;

    class dfa_outcome_checker;
        logic [STATE_W-1:0]  init_q;
        logic [MASK_W-1:0]   mask_q;
        logic [COUNT_W-1:0]  count_q;
        logic [STATE_W-1:0]  state_q;
        logic                flag_q;
        logic [STATE_W-1:0]  slot_from[TABLE_SLOTS];
        logic [SYMBOL_W-1:0] slot_sym[TABLE_SLOTS];
        logic [STATE_W-1:0]  slot_to[TABLE_SLOTS];
        dfa_outcome_t        expected_outcomes[$];
        int                  mismatches;

        function new();
            init_q     = '0;
            mask_q     = '0;
            count_q    = '0;
            state_q    = '0;
            flag_q     = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_INITIAL_STATE:  init_q  = data[STATE_W-1:0];
                REG_ACCEPTING_MASK: mask_q  = data[MASK_W-1:0];
                REG_ENTRY_COUNT:    count_q = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int slots_in_use();
            return (int'(count_q) > TABLE_SLOTS) ? TABLE_SLOTS : int'(count_q);
        endfunction

        function void take_item(dfa_item_t it);
            dfa_outcome_t o;
            logic         hit;
            int           n;
            hit = 1'b0;
            n   = slots_in_use();
            case (it.opcode)
                // every slot index and state number fits the table, so writes always land
                OP_WRITE:
                begin
                    slot_from[it.entry_index] = it.from_state;
                    slot_sym[it.entry_index]  = it.symbol;
                    slot_to[it.entry_index]   = it.to_state;
                end
                OP_STEP:
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        if (!hit && slot_from[i] == state_q && slot_sym[i] == it.symbol)
                        begin
                            state_q = slot_to[i];
                            flag_q  = mask_q[state_q];
                            hit     = 1'b1;
                        end
                    end
                end
                OP_RESTART:
                begin
                    state_q = init_q;
                    flag_q  = 1'b0;
                end
                default: ;
            endcase
            o.present_state = state_q;
            o.is_accepting  = flag_q;
            o.matched       = hit;
            expected_outcomes = {expected_outcomes, o};
        endfunction

        function void compare_outcome(dfa_outcome_t got);
            dfa_outcome_t e;
            if (expected_outcomes.size() == 0)
            begin
                $error("result transfer with no item outstanding");
                mismatches++;
                return;
            end
            e = expected_outcomes.pop_front();
            if (got.present_state !== e.present_state)
            begin
                $error("present_state: expected %0d, got %0d", e.present_state,
                       got.present_state);
                mismatches++;
            end
            if (got.is_accepting !== e.is_accepting)
            begin
                $error("is_accepting: expected %0d, got %0d", e.is_accepting, got.is_accepting);
                mismatches++;
            end
            if (got.matched !== e.matched)
            begin
                $error("matched: expected %0d, got %0d", e.matched, got.matched);
                mismatches++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 20;
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    int   cycles;
    bit   hold_req;

    dfa_outcome_checker tracker;

    pdfa_item_if   item_ch ();
    pdfa_result_if result_ch ();
    pdfa_cfg_if    cfg_ch ();

    programmable_dfa_runner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            tracker.compare_outcome({result_ch.present_state, result_ch.is_accepting,
                                     result_ch.matched});
    end

    // result side: random stall patterns, plus one long hold-off on request
    initial
    begin : receiver
        int   mode;
        int   span;
        int   hold_left;
        logic next_ready;
        span      = 0;
        mode      = 0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(3);
                    span = $urandom_range(5, 60);
                end
                span--;
                case (mode)
                    0:       next_ready = 1'b1;
                    1:       next_ready = 1'($urandom_range(1));
                    2:       next_ready = ($urandom_range(3) == 0);
                    default: next_ready = ($urandom_range(3) != 0);
                endcase
            end
            result_ch.ready <= next_ready;
        end
    end

    function automatic dfa_item_t mk_item(logic [OPCODE_W-1:0] op, int idx, int from,
                                          int sym, int to);
        dfa_item_t it;
        it.opcode      = op;
        it.entry_index = INDEX_W'(idx);
        it.from_state  = STATE_W'(from);
        it.symbol      = SYMBOL_W'(sym);
        it.to_state    = STATE_W'(to);
        return it;
    endfunction

    // small alphabet most of the time so that steps hit stored transitions
    function automatic logic [SYMBOL_W-1:0] pick_symbol();
        case ($urandom_range(5))
            0, 1, 2: return SYMBOL_W'($urandom_range(3));
            3:       return ~SYMBOL_W'($urandom_range(1));
            default: return SYMBOL_W'($urandom);
        endcase
    endfunction

    function automatic dfa_item_t next_item();
        dfa_item_t           it;
        logic [SYMBOL_W-1:0] live_syms[$];
        int                  r;
        r  = $urandom_range(99);
        it = mk_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
        if (r < 18)
        begin
            it.opcode = OP_WRITE;
            it.symbol = pick_symbol();
            if ($urandom_range(1))
                it.from_state = tracker.state_q;
            if ($urandom_range(1))
                it.to_state = STATE_W'($urandom_range(3));
        end
        else if (r < 83)
        begin
            it.opcode = OP_STEP;
            for (int i = 0; i < tracker.slots_in_use(); i++)
                if (tracker.slot_from[i] == tracker.state_q)
                    live_syms = {live_syms, tracker.slot_sym[i]};
            if (live_syms.size() > 0 && $urandom_range(3) != 0)
                it.symbol = live_syms[$urandom_range(live_syms.size() - 1)];
            else
                it.symbol = pick_symbol();
        end
        else if (r < 95)
            it.opcode = OP_RESTART;
        return it;
    endfunction

    // leaves valid high; the caller lowers it when the stream pauses
    task automatic push_item(dfa_item_t it);
        item_ch.valid       <= 1'b1;
        item_ch.opcode      <= it.opcode;
        item_ch.entry_index <= it.entry_index;
        item_ch.from_state  <= it.from_state;
        item_ch.symbol      <= it.symbol;
        item_ch.to_state    <= it.to_state;
        do @(posedge clk); while (item_ch.ready !== 1'b1);
        tracker.take_item(it);
    endtask

    task automatic send_items(int total, bit no_gaps);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < total)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < total)
            begin
                push_item(next_item());
                sent++;
                burst--;
            end
            gap = (no_gaps || $urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (tracker.expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(int init, int mask, int count);
        logic [CFG_INDEX_W-1:0] idx[3];
        logic [CFG_DATA_W-1:0]  val[3];
        idx = '{REG_INITIAL_STATE, REG_ACCEPTING_MASK, REG_ENTRY_COUNT};
        val = '{CFG_DATA_W'(init), CFG_DATA_W'(mask), CFG_DATA_W'(count)};
        for (int i = 0; i < 3; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do @(posedge clk); while (cfg_ch.ready !== 1'b1);
            tracker.write_reg(idx[i], val[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int init;
        int mask;
        int count;
        int n_items;
        tracker  = new();
        hold_req = 1'b0;
        rst_n    <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.opcode      <= OP_WRITE;
        item_ch.entry_index <= '0;
        item_ch.from_state  <= '0;
        item_ch.symbol      <= '0;
        item_ch.to_state    <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_INITIAL_STATE;
        cfg_ch.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no slot in use yet: a step cannot match, odd opcode and restart report state
        push_item(mk_item(OP_STEP, 0, 0, 0, 0));
        push_item(mk_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
        push_item(mk_item(OP_RESTART, $urandom, $urandom, $urandom, $urandom));
        // fill the whole table, with a duplicate key to check first-match order
        push_item(mk_item(OP_WRITE, 0, 0, 8'h00, 15));
        push_item(mk_item(OP_WRITE, 1, 15, 8'hFF, 0));
        push_item(mk_item(OP_WRITE, 2, 15, 8'hFF, 7));
        push_item(mk_item(OP_WRITE, 3, 0, 8'hAA, 5));
        push_item(mk_item(OP_WRITE, 4, 5, 8'h55, 10));
        for (int i = 5; i < TABLE_SLOTS - 1; i++)
            push_item(mk_item(OP_WRITE, i, i, i * 17, 15 - i));
        push_item(mk_item(OP_WRITE, 15, 15, 8'hFF, 0));
        item_ch.valid <= 1'b0;
        wait_idle();

        // initial state accepting, so the restart below must still clear the flag
        set_config(0, 16'h8001, TABLE_SLOTS);
        push_item(mk_item(OP_STEP, 0, 0, 8'h00, 0));
        push_item(mk_item(OP_STEP, 0, 0, 8'hFF, 0));
        push_item(mk_item(OP_STEP, 0, 0, 8'h13, 0));
        push_item(mk_item(OP_RESTART, 0, 0, 0, 0));
        item_ch.valid <= 1'b0;
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            init    = $urandom_range(15);
            mask    = $urandom_range(16'hFFFF);
            count   = $urandom_range(2, 15);
            n_items = 150;
            case (p)
                0:
                begin
                    init  = 15;
                    mask  = 16'hFFFF;
                    count = TABLE_SLOTS;
                end
                1:
                begin
                    init  = 0;
                    mask  = 0;
                    count = 31;
                end
                2:
                begin
                    init    = 7;
                    count   = 0;
                    n_items = 80;
                end
                3: count = 1;
                5:
                begin
                    init  = 3;
                    count = 20;
                end
                6: count = TABLE_SLOTS;
                7: count = $urandom_range(31);
                default: ;
            endcase
            set_config(init, mask, count);
            // first phase: receiver holds off while items keep coming, to back up the input
            if (p == 0)
                hold_req = 1'b1;
            send_items(n_items, p == 0);
            wait_idle();
        end

        if (tracker.mismatches == 0 && tracker.expected_outcomes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
